// File: design/tea_block_cipher_core_macros.svh
// Assertion helpers shared by the cipher core
`ifndef TEA_BLOCK_CIPHER_CORE_MACROS_SVH
`define TEA_BLOCK_CIPHER_CORE_MACROS_SVH

// Check a property on every clock edge outside reset
`define TEA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Check a property on every clock edge, reset included
`define TEA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: design/tea_pkg.sv
package tea_pkg;

   localparam int unsigned ROUNDS = 32;
   localparam int unsigned STAGES = 2 * ROUNDS;

   localparam logic [31:0] ROUND_DELTA = 32'h9E37_79B9;

   localparam int unsigned CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY0 = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY1 = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY2 = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY3 = CSR_INDEX_W'(3);

   typedef struct packed {
      logic [31:0] k0;
      logic [31:0] k1;
      logic [31:0] k2;
      logic [31:0] k3;
   } tea_key_type;

   typedef struct packed {
      logic        decrypt;
      logic [31:0] y;
      logic [31:0] z;
   } tea_block_type;

   typedef struct packed {
      logic        second_half;
      logic [31:0] enc_sum;
      logic [31:0] dec_sum;
   } tea_round_ctl_type;

   typedef struct packed {
      logic advance;
      logic held;
   } tea_skid_status_type;

   function automatic logic [31:0] tea_round_sum(input int unsigned count);
      logic [63:0] product;
      product = 64'(count) * 64'(ROUND_DELTA);
      return product[31:0];
   endfunction

endpackage

// File: design/tea_key_regs.sv
module tea_key_regs import tea_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_wdata,
   output tea_key_type            key
);

   tea_key_type key_ff;
   tea_key_type key_in;

   always_comb begin
      key_in = key_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_KEY0: key_in.k0 = csr_wdata;
            CSR_KEY1: key_in.k1 = csr_wdata;
            CSR_KEY2: key_in.k2 = csr_wdata;
            CSR_KEY3: key_in.k3 = csr_wdata;
            default:  key_in    = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   assign key = key_ff;

endmodule

// File: design/tea_half_round.sv
module tea_half_round import tea_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  tea_round_ctl_type ctl,
   input  tea_key_type       key,
   input  logic              vld_in,
   input  tea_block_type     blk_in,
   output logic              vld_out,
   output tea_block_type     blk_out
);

   function automatic logic [31:0] tea_mix(input logic [31:0] w, input logic [31:0] s,
                                           input logic [31:0] ka, input logic [31:0] kb);
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      a = (w << 4) + ka;
      b = w + s;
      c = (w >> 5) + kb;
      return a ^ b ^ c;
   endfunction

   logic          stage_vld_ff;
   logic          stage_vld_in;
   tea_block_type stage_blk_ff;
   tea_block_type stage_blk_in;

   logic        update_y;
   logic [31:0] src_word;
   logic [31:0] dst_word;
   logic [31:0] sum;
   logic [31:0] ka;
   logic [31:0] kb;
   logic [31:0] term;
   logic [31:0] new_word;

   always_comb begin
      update_y = ~(ctl.second_half ^ blk_in.decrypt);
      src_word = update_y ? blk_in.z : blk_in.y;
      dst_word = update_y ? blk_in.y : blk_in.z;
      sum      = blk_in.decrypt ? ctl.dec_sum : ctl.enc_sum;
      ka       = update_y ? key.k0 : key.k2;
      kb       = update_y ? key.k1 : key.k3;
      term     = tea_mix(src_word, sum, ka, kb);
      new_word = blk_in.decrypt ? dst_word - term : dst_word + term;

      stage_blk_in = blk_in;
      if (update_y) begin
         stage_blk_in.y = new_word;
      end else begin
         stage_blk_in.z = new_word;
      end
      stage_vld_in = advance ? vld_in : stage_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= 1'b0;
      end else begin
         stage_vld_ff <= stage_vld_in;
      end
   end

   // advance the block only when the pipeline moves
   always_ff @(posedge clock) begin
      if (advance) begin
         stage_blk_ff <= stage_blk_in;
      end
   end

   assign vld_out = stage_vld_ff;
   assign blk_out = stage_blk_ff;

endmodule

// File: design/tea_skid.sv
module tea_skid import tea_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                last_vld,
   input  logic [63:0]         last_data,
   input  logic                rsp_tready,
   output logic                rsp_tvalid,
   output logic [63:0]         rsp_tdata,
   output tea_skid_status_type status
);

   logic        held_ff;
   logic        held_in;
   logic [63:0] data_ff;
   logic [63:0] data_in;

   always_comb begin
      if (held_ff) begin
         held_in = ~rsp_tready;
         data_in = data_ff;
      end else begin
         held_in = last_vld & ~rsp_tready;
         data_in = last_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 1'b0;
      end else begin
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_tvalid     = held_ff | last_vld;
   assign rsp_tdata      = held_ff ? data_ff : last_data;
   assign status.advance = ~held_ff;
   assign status.held    = held_ff;

endmodule

// File: design/tea_block_cipher_core.sv
// An accepted req word passes through every half-round stage register in order before rsp_tvalid.
// Throughput: one block per cycle while the skid register is empty, one half-round per pipeline stage.
// A stalled rsp word parks in a skid register; the pipeline then holds.
// Reset: synchronous, active high; clears stage valids, the skid held flag and key registers.
`include "tea_block_cipher_core_macros.svh"

module tea_block_cipher_core import tea_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [63:0]            req_tdata,  // first_word, second_word
   input  logic                   req_tuser,  // req_type
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [63:0]            rsp_tdata,  // result_first, result_second
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_wdata
);

   tea_key_type         key;
   tea_skid_status_type skid_status;
   tea_block_type       req_blk;
   logic [STAGES-1:0]   stage_vld;
   tea_block_type       stage_blk [STAGES];
   logic [63:0]         last_data;

   tea_key_regs u_key_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .key       (key)
   );

   assign req_blk.decrypt = req_tuser;
   assign req_blk.y       = req_tdata[31:0];
   assign req_blk.z       = req_tdata[63:32];

   for (genvar j = 0; j < STAGES; j++) begin : g_stage
      localparam tea_round_ctl_type CTL = '{
         second_half: 1'(j % 2),
         enc_sum:     tea_round_sum(j / 2 + 1),
         dec_sum:     tea_round_sum(ROUNDS - j / 2)
      };
      logic          vld_src;
      tea_block_type blk_src;

      if (j == 0) begin : g_head
         assign vld_src = req_tvalid;
         assign blk_src = req_blk;
      end else begin : g_body
         assign vld_src = stage_vld[j-1];
         assign blk_src = stage_blk[j-1];
      end

      tea_half_round u_half_round (
         .clock   (clock),
         .reset   (reset),
         .advance (skid_status.advance),
         .ctl     (CTL),
         .key     (key),
         .vld_in  (vld_src),
         .blk_in  (blk_src),
         .vld_out (stage_vld[j]),
         .blk_out (stage_blk[j])
      );
   end

   assign last_data = {stage_blk[STAGES-1].z, stage_blk[STAGES-1].y};

   tea_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .last_vld   (stage_vld[STAGES-1]),
      .last_data  (last_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .status     (skid_status)
   );

   assign req_tready = skid_status.advance;

   `TEA_ASSERT(a_hold_freezes_pipe, skid_status.held |=> stage_vld == $past(stage_vld), "pipeline moved while the skid register was full")
   `TEA_ASSERT(a_skid_loads_stalled_word, $rose(skid_status.held) |-> $past(stage_vld[STAGES-1] && !rsp_tready), "skid register filled without a stalled word")
   `TEA_ASSERT_ALWAYS(a_reset_empties_pipe, $past(reset) |-> (stage_vld == '0) && !rsp_tvalid, "pipeline not empty after reset")

endmodule
